@@ rtl/core/ecsm_pkg.sv @@
// Shared types, constants and the point-operation microprogram for the
// affine scalar multiplier. No dependencies.
`timescale 1ns / 1ps

package ecsm_pkg;

    localparam int WORD_WIDTH_DEF = 64;  // default working width
    localparam int FIELD_W        = 64;  // width of the point, scalar and configuration data ports
    localparam int CFG_IDX_W      = 8;
    localparam int ADDR_W         = 4;   // scratch memory address width
    localparam int PC_W           = 6;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_A     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_PRIME = 8'd1;

    // scratch memory slots
    localparam logic [ADDR_W-1:0] S_RX = 4'd0;
    localparam logic [ADDR_W-1:0] S_RY = 4'd1;
    localparam logic [ADDR_W-1:0] S_BX = 4'd2;
    localparam logic [ADDR_W-1:0] S_BY = 4'd3;
    localparam logic [ADDR_W-1:0] S_CA = 4'd4;
    localparam logic [ADDR_W-1:0] S_T0 = 4'd5;
    localparam logic [ADDR_W-1:0] S_T1 = 4'd6;
    localparam logic [ADDR_W-1:0] S_T2 = 4'd7;
    localparam logic [ADDR_W-1:0] S_T3 = 4'd8;

    // entry points of the microprogram
    localparam logic [PC_W-1:0] PC_INIT = 6'd0;
    localparam logic [PC_W-1:0] PC_DBL  = 6'd6;
    localparam logic [PC_W-1:0] PC_ADD  = 6'd22;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_RED  = 4'd3,
        OP_INV  = 4'd4,
        OP_MOV  = 4'd5,
        OP_ZERO = 4'd6,
        OP_TZ   = 4'd7,
        OP_TEQ  = 4'd8
    } alu_op_t;

    typedef enum logic [2:0] {
        CK_NEXT   = 3'd0,
        CK_BRZ    = 3'd1,
        CK_BRNI   = 3'd2,
        CK_LOOP   = 3'd3,
        CK_DBLEND = 3'd4,
        CK_FIN    = 3'd5
    } ctrl_t;

    typedef struct packed {
        alu_op_t           op;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] sb;
        ctrl_t             ck;
        logic [PC_W-1:0]   tgt;
    } uinstr_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic done;
        logic z;
        logic noinv;
    } alu_stat_t;

    function automatic uinstr_t mk(alu_op_t op, logic [ADDR_W-1:0] dst,
                                   logic [ADDR_W-1:0] sa, logic [ADDR_W-1:0] sb,
                                   ctrl_t ck, logic [PC_W-1:0] tgt);
        uinstr_t u;
        u.op  = op;
        u.dst = dst;
        u.sa  = sa;
        u.sb  = sb;
        u.ck  = ck;
        u.tgt = tgt;
        return u;
    endfunction

    function automatic logic op_writes(alu_op_t op);
        return !(op == OP_TZ || op == OP_TEQ);
    endfunction

    // microprogram: reduction of the inputs, point doubling, point addition
    function automatic uinstr_t ucode(logic [PC_W-1:0] pc);
        uinstr_t u;
        case (pc)
            6'd0:  u = mk(OP_RED,  S_BX, S_BX, S_BX, CK_NEXT, 6'd0);
            6'd1:  u = mk(OP_RED,  S_BY, S_BY, S_BY, CK_NEXT, 6'd0);
            6'd2:  u = mk(OP_RED,  S_CA, S_CA, S_CA, CK_NEXT, 6'd0);
            6'd3:  u = mk(OP_TZ,   S_T0, S_BX, S_BY, CK_BRZ,  6'd40);
            6'd4:  u = mk(OP_MOV,  S_RX, S_BX, S_BX, CK_NEXT, 6'd0);
            6'd5:  u = mk(OP_MOV,  S_RY, S_BY, S_BY, CK_LOOP, 6'd0);
            // doubling
            6'd6:  u = mk(OP_ADD,  S_T0, S_RY, S_RY, CK_NEXT, 6'd0);
            6'd7:  u = mk(OP_INV,  S_T1, S_T0, S_T0, CK_BRNI, 6'd20);
            6'd8:  u = mk(OP_MUL,  S_T2, S_RX, S_RX, CK_NEXT, 6'd0);
            6'd9:  u = mk(OP_ADD,  S_T3, S_T2, S_T2, CK_NEXT, 6'd0);
            6'd10: u = mk(OP_ADD,  S_T2, S_T3, S_T2, CK_NEXT, 6'd0);
            6'd11: u = mk(OP_ADD,  S_T2, S_T2, S_CA, CK_NEXT, 6'd0);
            6'd12: u = mk(OP_MUL,  S_T1, S_T2, S_T1, CK_NEXT, 6'd0);
            6'd13: u = mk(OP_MUL,  S_T2, S_T1, S_T1, CK_NEXT, 6'd0);
            6'd14: u = mk(OP_ADD,  S_T3, S_RX, S_RX, CK_NEXT, 6'd0);
            6'd15: u = mk(OP_SUB,  S_T2, S_T2, S_T3, CK_NEXT, 6'd0);
            6'd16: u = mk(OP_SUB,  S_T3, S_RX, S_T2, CK_NEXT, 6'd0);
            6'd17: u = mk(OP_MUL,  S_T3, S_T1, S_T3, CK_NEXT, 6'd0);
            6'd18: u = mk(OP_SUB,  S_RY, S_T3, S_RY, CK_NEXT, 6'd0);
            6'd19: u = mk(OP_MOV,  S_RX, S_T2, S_T2, CK_DBLEND, 6'd0);
            6'd20: u = mk(OP_ZERO, S_RX, S_RX, S_RX, CK_NEXT, 6'd0);
            6'd21: u = mk(OP_ZERO, S_RY, S_RY, S_RY, CK_DBLEND, 6'd0);
            // addition of the base point
            6'd22: u = mk(OP_TZ,   S_T0, S_RX, S_RY, CK_BRZ,  6'd38);
            6'd23: u = mk(OP_TEQ,  S_T0, S_RX, S_BX, CK_BRZ,  6'd35);
            6'd24: u = mk(OP_SUB,  S_T0, S_BX, S_RX, CK_NEXT, 6'd0);
            6'd25: u = mk(OP_INV,  S_T1, S_T0, S_T0, CK_BRNI, 6'd36);
            6'd26: u = mk(OP_SUB,  S_T2, S_BY, S_RY, CK_NEXT, 6'd0);
            6'd27: u = mk(OP_MUL,  S_T1, S_T2, S_T1, CK_NEXT, 6'd0);
            6'd28: u = mk(OP_MUL,  S_T2, S_T1, S_T1, CK_NEXT, 6'd0);
            6'd29: u = mk(OP_SUB,  S_T2, S_T2, S_RX, CK_NEXT, 6'd0);
            6'd30: u = mk(OP_SUB,  S_T2, S_T2, S_BX, CK_NEXT, 6'd0);
            6'd31: u = mk(OP_SUB,  S_T3, S_RX, S_T2, CK_NEXT, 6'd0);
            6'd32: u = mk(OP_MUL,  S_T3, S_T1, S_T3, CK_NEXT, 6'd0);
            6'd33: u = mk(OP_SUB,  S_RY, S_T3, S_RY, CK_NEXT, 6'd0);
            6'd34: u = mk(OP_MOV,  S_RX, S_T2, S_T2, CK_LOOP, 6'd0);
            6'd35: u = mk(OP_TEQ,  S_T0, S_RY, S_BY, CK_BRZ,  PC_DBL);
            6'd36: u = mk(OP_ZERO, S_RX, S_RX, S_RX, CK_NEXT, 6'd0);
            6'd37: u = mk(OP_ZERO, S_RY, S_RY, S_RY, CK_LOOP, 6'd0);
            6'd38: u = mk(OP_MOV,  S_RX, S_BX, S_BX, CK_NEXT, 6'd0);
            6'd39: u = mk(OP_MOV,  S_RY, S_BY, S_BY, CK_LOOP, 6'd0);
            // base reduced to infinity
            6'd40: u = mk(OP_ZERO, S_RX, S_RX, S_RX, CK_NEXT, 6'd0);
            6'd41: u = mk(OP_ZERO, S_RY, S_RY, S_RY, CK_FIN,  6'd0);
            default: u = mk(OP_ZERO, S_T0, S_T0, S_T0, CK_FIN, 6'd0);
        endcase
        return u;
    endfunction

endpackage

@@ rtl/core/ec_scalar_multiply_affine_core.sv @@
// Top level of the affine double-and-add scalar multiplier: sequencer,
// configuration registers and output register. Depends on ecsm_pkg,
// ecsm_regfile and ecsm_alu.
`timescale 1ns / 1ps

// One item at a time. An item first shifts the scalar until its top set bit
// sits in the msb, then makes three loads and three reductions, then per lower
// scalar bit one doubling and, for a set bit, one addition. Each point operation
// runs its microprogram through the arithmetic unit, each step passing the
// fetch, execute and wait states; the inverse, with its Euclid quotient steps,
// dominates. A zero scalar or a modulus below two goes straight to the output
// capture. Working values live in a 16-entry scratch memory with registered
// read ports; the microprogram never reads an entry in the cycle it is written.
// A new item is taken while a finished result waits on the output.
module ec_scalar_multiply_affine_core #(
    parameter int WORD_WIDTH = ecsm_pkg::WORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ecsm_pkg::FIELD_W-1:0]   base_x,
    input  logic [ecsm_pkg::FIELD_W-1:0]   base_y,
    input  logic [ecsm_pkg::FIELD_W-1:0]   scalar,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ecsm_pkg::FIELD_W-1:0]   result_x,
    output logic [ecsm_pkg::FIELD_W-1:0]   result_y,
    output logic                           bad_scalar,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ecsm_pkg::FIELD_W-1:0]   cfg_data
);
    import ecsm_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(W);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_NORM  = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_FETCH = 9'b000001000,
        ST_EXEC  = 9'b000010000,
        ST_WAIT  = 9'b000100000,
        ST_RDOUT = 9'b001000000,
        ST_CAPT  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t          state_reg;
    logic [W-1:0]    ca_reg, p_reg;
    logic [W-1:0]    inx_reg, iny_reg, k_reg;
    logic [CW-1:0]   bcnt_reg;
    logic [1:0]      lcnt_reg;
    logic [PC_W-1:0] pc_reg;
    logic            in_add_reg, fin_zero_reg, bad_reg;
    logic            out_valid_reg, out_bad_reg;
    logic [W-1:0]    out_x_reg, out_y_reg;

    uinstr_t           cur;
    alu_ctl_t          alu_ctl;
    alu_stat_t         alu_stat;
    logic [W-1:0]      alu_res;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic [W-1:0]      wdata, rdata_a, rdata_b;
    logic              out_free, acc_in;

    assign cur       = ucode(pc_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign acc_in    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        alu_ctl.start = (state_reg == ST_EXEC);
        alu_ctl.op    = cur.op;
        mem_we  = 1'b0;
        waddr   = cur.dst;
        wdata   = alu_res;
        raddr_a = cur.sa;
        raddr_b = cur.sb;
        case (state_reg)
            ST_LOAD:
            begin
                mem_we = 1'b1;
                case (lcnt_reg)
                    2'd0:
                    begin
                        waddr = S_BX;
                        wdata = inx_reg;
                    end
                    2'd1:
                    begin
                        waddr = S_BY;
                        wdata = iny_reg;
                    end
                    default:
                    begin
                        waddr = S_CA;
                        wdata = ca_reg;
                    end
                endcase
            end
            ST_WAIT:  mem_we = alu_stat.done && op_writes(cur.op);
            ST_RDOUT,
            ST_CAPT:
            begin
                raddr_a = S_RX;
                raddr_b = S_RY;
            end
            default: mem_we = 1'b0;
        endcase
    end

    ecsm_regfile #(.W(W)) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    ecsm_alu #(.W(W)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .opa    (rdata_a),
        .opb    (rdata_b),
        .p      (p_reg),
        .result (alu_res),
        .stat   (alu_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= W'(2);
            p_reg  <= W'(17);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_CURVE_A)
            begin
                ca_reg <= cfg_data[W-1:0];
            end
            else if (cfg_index == REG_FIELD_PRIME)
            begin
                p_reg <= cfg_data[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            in_add_reg    <= 1'b0;
            pc_reg        <= PC_INIT;
        end
        else
        begin
            // a capture in the same cycle refills the register instead
            if (out_valid_reg && out_ready && state_reg != ST_CAPT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in)
                    begin
                        inx_reg  <= base_x[W-1:0];
                        iny_reg  <= base_y[W-1:0];
                        k_reg    <= scalar[W-1:0];
                        bcnt_reg <= CW'(W - 1);
                        if (scalar[W-1:0] == '0)
                        begin
                            fin_zero_reg <= 1'b1;
                            bad_reg      <= 1'b1;
                            state_reg    <= ST_CAPT;
                        end
                        else if (p_reg < W'(2))
                        begin
                            fin_zero_reg <= 1'b1;
                            bad_reg      <= 1'b0;
                            state_reg    <= ST_CAPT;
                        end
                        else
                        begin
                            fin_zero_reg <= 1'b0;
                            bad_reg      <= 1'b0;
                            state_reg    <= ST_NORM;
                        end
                    end
                end
                ST_NORM:
                begin
                    // shift until the top set bit sits in the msb
                    if (k_reg[W-1])
                    begin
                        lcnt_reg  <= 2'd0;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        k_reg    <= k_reg << 1;
                        bcnt_reg <= bcnt_reg - 1'b1;
                    end
                end
                ST_LOAD:
                begin
                    lcnt_reg <= lcnt_reg + 1'b1;
                    if (lcnt_reg == 2'd2)
                    begin
                        pc_reg     <= PC_INIT;
                        in_add_reg <= 1'b0;
                        state_reg  <= ST_FETCH;
                    end
                end
                ST_FETCH: state_reg <= ST_EXEC;
                ST_EXEC:  state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (alu_stat.done)
                    begin
                        case (cur.ck)
                            CK_NEXT:
                            begin
                                pc_reg    <= pc_reg + 1'b1;
                                state_reg <= ST_FETCH;
                            end
                            CK_BRZ:
                            begin
                                pc_reg    <= alu_stat.z ? cur.tgt : pc_reg + 1'b1;
                                state_reg <= ST_FETCH;
                            end
                            CK_BRNI:
                            begin
                                pc_reg    <= alu_stat.noinv ? cur.tgt : pc_reg + 1'b1;
                                state_reg <= ST_FETCH;
                            end
                            CK_DBLEND:
                            begin
                                if (!in_add_reg && k_reg[W-1])
                                begin
                                    in_add_reg <= 1'b1;
                                    pc_reg     <= PC_ADD;
                                    state_reg  <= ST_FETCH;
                                end
                                else if (bcnt_reg == '0)
                                begin
                                    state_reg <= ST_RDOUT;
                                end
                                else
                                begin
                                    k_reg      <= k_reg << 1;
                                    bcnt_reg   <= bcnt_reg - 1'b1;
                                    in_add_reg <= 1'b0;
                                    pc_reg     <= PC_DBL;
                                    state_reg  <= ST_FETCH;
                                end
                            end
                            CK_LOOP:
                            begin
                                // advance to the next scalar bit, or finish
                                if (bcnt_reg == '0)
                                begin
                                    state_reg <= ST_RDOUT;
                                end
                                else
                                begin
                                    k_reg      <= k_reg << 1;
                                    bcnt_reg   <= bcnt_reg - 1'b1;
                                    in_add_reg <= 1'b0;
                                    pc_reg     <= PC_DBL;
                                    state_reg  <= ST_FETCH;
                                end
                            end
                            default: state_reg <= ST_RDOUT;
                        endcase
                    end
                end
                ST_RDOUT: state_reg <= ST_CAPT;
                ST_CAPT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_x_reg     <= fin_zero_reg ? '0 : rdata_a;
                        out_y_reg     <= fin_zero_reg ? '0 : rdata_b;
                        out_bad_reg   <= bad_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:  state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_x   = FIELD_W'(out_x_reg);
    assign result_y   = FIELD_W'(out_y_reg);
    assign bad_scalar = out_bad_reg;

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> (state_reg == ST_WAIT))
        else $error("arithmetic result arrived outside the wait state");

    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_LOAD || state_reg == ST_WAIT))
        else $error("scratch write outside load or write-back");

    a_capt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CAPT && out_valid_reg && !out_ready) |=> (state_reg == ST_CAPT))
        else $error("result captured over an untaken beat");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_x_reg == '0 && out_y_reg == '0))
        else $error("bad scalar with non-zero point");
`endif

endmodule

@@ rtl/core/ecsm_regfile.sv @@
// Scratch memory for coordinates and temporaries: one write port and two
// registered read ports. Depends on ecsm_pkg.
`timescale 1ns / 1ps

module ecsm_regfile #(
    parameter int W = ecsm_pkg::WORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ecsm_pkg::ADDR_W-1:0] waddr,
    input  logic [W-1:0]                wdata,
    input  logic [ecsm_pkg::ADDR_W-1:0] raddr_a,
    input  logic [ecsm_pkg::ADDR_W-1:0] raddr_b,
    output logic [W-1:0]                rdata_a,
    output logic [W-1:0]                rdata_b
);
    import ecsm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/core/ecsm_alu.sv @@
// Modular arithmetic unit: add, subtract, move, zero and equality tests, bit-serial
// multiply, reduction and a Euclidean inverse that reuses both. Depends on ecsm_pkg.
`timescale 1ns / 1ps

module ecsm_alu #(
    parameter int W = ecsm_pkg::WORD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ecsm_pkg::alu_ctl_t  ctl,
    input  logic [W-1:0]        opa,
    input  logic [W-1:0]        opb,
    input  logic [W-1:0]        p,
    output logic [W-1:0]        result,
    output ecsm_pkg::alu_stat_t stat
);
    import ecsm_pkg::*;

    localparam int CW = $clog2(W);

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_MUL  = 6'b000010,
        A_DIV  = 6'b000100,
        A_CHK  = 6'b001000,
        A_QM   = 6'b010000,
        A_UPD  = 6'b100000
    } astate_t;

    astate_t       state_reg;
    alu_op_t       op_reg;
    logic          done_reg, z_reg, noinv_reg;
    logic          done_next;
    logic [W-1:0]  result_reg;
    logic [W-1:0]  acc_reg, ma_reg, mb_reg;
    logic          phase_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg, dsh_reg, d_reg, q_reg;
    logic [W-1:0]  r0_reg, r1_reg, t0_reg, t1_reg;

    function automatic logic [W-1:0] addmod(logic [W-1:0] x, logic [W-1:0] y,
                                            logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] submod(logic [W-1:0] x, logic [W-1:0] y,
                                            logic [W-1:0] m);
        logic [W-1:0] d;
        d = x - y;
        if (x < y)
        begin
            d = d + m;
        end
        return d;
    endfunction

    logic [W-1:0] mul_y, acc_sum, qm, rem_n, simple_res;
    logic [W:0]   div_t, div_diff;
    logic         div_ge, simple_z;

    always_comb
    begin
        mul_y   = phase_reg ? ma_reg : acc_reg;
        acc_sum = addmod(acc_reg, mul_y, p);
        div_t    = {rem_reg, dsh_reg[W-1]};
        div_ge   = div_t >= {1'b0, d_reg};
        div_diff = div_t - {1'b0, d_reg};
        rem_n    = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
        qm = (q_reg >= p) ? (q_reg - p) : q_reg;
        simple_z = 1'b0;
        case (ctl.op)
            OP_ADD:  simple_res = addmod(opa, opb, p);
            OP_SUB:  simple_res = submod(opa, opb, p);
            OP_MOV:  simple_res = opa;
            OP_TZ:
            begin
                simple_res = '0;
                simple_z   = (opa == '0) && (opb == '0);
            end
            OP_TEQ:
            begin
                simple_res = '0;
                simple_z   = (opa == opb);
            end
            default: simple_res = '0;
        endcase
    end

    // one-cycle done pulse on every finishing path
    always_comb
    begin
        case (state_reg)
            A_IDLE:
                done_next = ctl.start && (ctl.op != OP_MUL) && (ctl.op != OP_RED)
                            && (ctl.op != OP_INV);
            A_MUL:
                done_next = (phase_reg || !mb_reg[W-1]) && (cnt_reg == '0)
                            && (op_reg != OP_INV);
            A_DIV:   done_next = (cnt_reg == '0) && (op_reg == OP_RED);
            A_CHK:   done_next = (r1_reg == '0);
            default: done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    if (ctl.start)
                    begin
                        op_reg <= ctl.op;
                        case (ctl.op)
                            OP_MUL:
                            begin
                                ma_reg    <= opa;
                                mb_reg    <= opb;
                                acc_reg   <= '0;
                                phase_reg <= 1'b0;
                                cnt_reg   <= CW'(W - 1);
                                state_reg <= A_MUL;
                            end
                            OP_RED:
                            begin
                                rem_reg   <= '0;
                                dsh_reg   <= opa;
                                d_reg     <= p;
                                cnt_reg   <= CW'(W - 1);
                                state_reg <= A_DIV;
                            end
                            OP_INV:
                            begin
                                r0_reg    <= p;
                                r1_reg    <= opa;
                                t0_reg    <= '0;
                                t1_reg    <= W'(1);
                                state_reg <= A_CHK;
                            end
                            default:
                            begin
                                result_reg <= simple_res;
                                z_reg      <= simple_z;
                                noinv_reg  <= 1'b0;
                            end
                        endcase
                    end
                end
                A_MUL:
                begin
                    acc_reg <= acc_sum;
                    if (!phase_reg && mb_reg[W-1])
                    begin
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        mb_reg    <= mb_reg << 1;
                        if (cnt_reg == '0)
                        begin
                            if (op_reg == OP_INV)
                            begin
                                state_reg <= A_UPD;
                            end
                            else
                            begin
                                result_reg <= acc_sum;
                                z_reg      <= (acc_sum == '0);
                                noinv_reg  <= 1'b0;
                                state_reg  <= A_IDLE;
                            end
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                    end
                end
                A_DIV:
                begin
                    rem_reg <= rem_n;
                    dsh_reg <= dsh_reg << 1;
                    q_reg   <= {q_reg[W-2:0], div_ge};
                    if (cnt_reg == '0)
                    begin
                        if (op_reg == OP_RED)
                        begin
                            result_reg <= rem_n;
                            z_reg      <= (rem_n == '0);
                            noinv_reg  <= 1'b0;
                            state_reg  <= A_IDLE;
                        end
                        else
                        begin
                            state_reg <= A_QM;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                A_QM:
                begin
                    // quotient times t1, reduced, in the shared multiplier
                    ma_reg    <= qm;
                    mb_reg    <= t1_reg;
                    acc_reg   <= '0;
                    phase_reg <= 1'b0;
                    cnt_reg   <= CW'(W - 1);
                    state_reg <= A_MUL;
                end
                A_UPD:
                begin
                    r0_reg    <= r1_reg;
                    r1_reg    <= rem_reg;
                    t0_reg    <= t1_reg;
                    t1_reg    <= submod(t0_reg, acc_reg, p);
                    state_reg <= A_CHK;
                end
                A_CHK:
                begin
                    if (r1_reg == '0)
                    begin
                        result_reg <= t0_reg;
                        z_reg      <= (t0_reg == '0);
                        noinv_reg  <= (r0_reg != W'(1));
                        state_reg  <= A_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        dsh_reg   <= r0_reg;
                        d_reg     <= r1_reg;
                        cnt_reg   <= CW'(W - 1);
                        state_reg <= A_DIV;
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign result     = result_reg;
    assign stat.done  = done_reg;
    assign stat.z     = z_reg;
    assign stat.noinv = noinv_reg;

endmodule
